FILE: rtl/tspf_pkg.sv
package tspf_pkg;

  localparam int unsigned PKT_LEN   = 188;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned NUM_SLOTS = 4;
  localparam int unsigned PID_W     = 13;

  localparam logic [7:0]       SYNC_BYTE = 8'h47;
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(PKT_LEN - 1);

  typedef logic [PID_W-1:0] pid_t;

  typedef enum logic [2:0] {
    CFG_SLOT_ZERO  = 3'd0,
    CFG_SLOT_ONE   = 3'd1,
    CFG_SLOT_TWO   = 3'd2,
    CFG_SLOT_THREE = 3'd3,
    CFG_ENABLE     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    pid_t [NUM_SLOTS-1:0] slot;
    logic [NUM_SLOTS-1:0] enable;
  } filter_cfg_t;

endpackage

FILE: rtl/tspf_pid_match.sv
module tspf_pid_match (
  input  tspf_pkg::filter_cfg_t filter_cfg,
  input  tspf_pkg::pid_t        pid,
  output logic                  hit
);

  logic [tspf_pkg::NUM_SLOTS-1:0] slot_hit;

  always_comb begin
    for (int i = 0; i < tspf_pkg::NUM_SLOTS; i++) begin
      slot_hit[i] = filter_cfg.enable[i] && (filter_cfg.slot[i] == pid);
    end
  end

  // any enabled slot holding the pid keeps the packet
  assign hit = |slot_hit;

endmodule

FILE: rtl/ts_packet_sync_pid_filter_core.sv
// Transport stream PID filter: takes one stream byte per cycle, hunts for the
// 0x47 sync byte, counts 188-byte packets, decodes the header and forwards the
// payload bytes of error-free packets whose PID matches an enabled filter slot,
// with the adaptation field and pointer field stripped. A byte is taken in
// every cycle in which the output register is empty or being drained; its
// result, if any, is shown from the output register in the next cycle. The
// user must write filter slots through the cfg port while idle; not enforced.
module ts_packet_sync_pid_filter_core (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_payload_byte,
  output logic [12:0] out_stream_pid,
  output logic [3:0]  out_continuity_count,
  output logic        out_section_start,
  output logic        out_packet_last,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  tspf_pkg::filter_cfg_t filter_cfg_r;

  logic                       in_packet_r, in_packet_nxt;
  logic [tspf_pkg::POS_W-1:0] pos_r, pos_nxt;
  tspf_pkg::pid_t             pid_r, pid_nxt;
  logic                       error_r, error_nxt;
  logic                       start_r, start_nxt;
  logic [1:0]                 adapt_r, adapt_nxt;
  logic [3:0]                 cc_r, cc_nxt;
  logic                       accepted_r, accepted_nxt;
  logic [7:0]                 skip_r, skip_nxt;
  logic                       pointer_r, pointer_nxt;
  logic                       first_r, first_nxt;

  logic                       out_valid_r;
  logic [7:0]                 out_byte_r;
  tspf_pkg::pid_t             out_pid_r;
  logic [3:0]                 out_cc_r;
  logic                       out_start_r;
  logic                       out_last_r;

  logic                       in_fire;
  logic                       active;
  logic [tspf_pkg::POS_W-1:0] pos;
  logic                       last;
  logic                       emit;
  logic                       pid_hit;
  tspf_pkg::pid_t             pid_full;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // while hunting, only a sync byte opens a packet at position zero
  assign active = in_packet_r || (in_stream_byte == tspf_pkg::SYNC_BYTE);
  assign pos    = in_packet_r ? pos_r : '0;
  assign last   = (pos >= tspf_pkg::LAST_POS);

  assign pid_full = {pid_r[12:8], in_stream_byte};

  tspf_pid_match u_pid_match (
    .filter_cfg (filter_cfg_r),
    .pid        (pid_full),
    .hit        (pid_hit)
  );

  always_comb begin
    in_packet_nxt = in_packet_r;
    pos_nxt       = pos_r;
    pid_nxt       = pid_r;
    error_nxt     = error_r;
    start_nxt     = start_r;
    adapt_nxt     = adapt_r;
    cc_nxt        = cc_r;
    accepted_nxt  = accepted_r;
    skip_nxt      = skip_r;
    pointer_nxt   = pointer_r;
    first_nxt     = first_r;
    emit          = 1'b0;
    if (in_fire && active) begin
      if (pos == tspf_pkg::POS_W'(0)) begin
        // sync byte
      end else if (pos == tspf_pkg::POS_W'(1)) begin
        error_nxt = in_stream_byte[7];
        start_nxt = in_stream_byte[6];
        pid_nxt   = {in_stream_byte[4:0], 8'h00};
      end else if (pos == tspf_pkg::POS_W'(2)) begin
        pid_nxt      = pid_full;
        accepted_nxt = pid_hit;
      end else if (pos == tspf_pkg::POS_W'(3)) begin
        adapt_nxt   = in_stream_byte[5:4];
        cc_nxt      = in_stream_byte[3:0];
        pointer_nxt = start_r;
        first_nxt   = 1'b0;
        skip_nxt    = '0;
      end else if (!error_r && accepted_r && adapt_r[0]) begin
        if (pos == tspf_pkg::POS_W'(4) && adapt_r[1]) begin
          skip_nxt = in_stream_byte;
        end else if (skip_r != '0) begin
          skip_nxt = skip_r - 8'd1;
        end else if (pointer_r) begin
          skip_nxt    = in_stream_byte;
          pointer_nxt = 1'b0;
          first_nxt   = 1'b1;
        end else begin
          emit      = 1'b1;
          first_nxt = 1'b0;
        end
      end
      if (last) begin
        in_packet_nxt = 1'b0;
        pos_nxt       = '0;
      end else begin
        in_packet_nxt = 1'b1;
        pos_nxt       = pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tspf_pkg::NUM_SLOTS; i++) begin
        filter_cfg_r.slot[i] <= '1;
      end
      filter_cfg_r.enable <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tspf_pkg::CFG_SLOT_ZERO:  filter_cfg_r.slot[0] <= cfg_data;
        tspf_pkg::CFG_SLOT_ONE:   filter_cfg_r.slot[1] <= cfg_data;
        tspf_pkg::CFG_SLOT_TWO:   filter_cfg_r.slot[2] <= cfg_data;
        tspf_pkg::CFG_SLOT_THREE: filter_cfg_r.slot[3] <= cfg_data;
        tspf_pkg::CFG_ENABLE:     filter_cfg_r.enable  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r <= 1'b0;
      pos_r       <= '0;
      pid_r       <= '0;
      error_r     <= 1'b0;
      start_r     <= 1'b0;
      adapt_r     <= '0;
      cc_r        <= '0;
      accepted_r  <= 1'b0;
      skip_r      <= '0;
      pointer_r   <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      in_packet_r <= in_packet_nxt;
      pos_r       <= pos_nxt;
      pid_r       <= pid_nxt;
      error_r     <= error_nxt;
      start_r     <= start_nxt;
      adapt_r     <= adapt_nxt;
      cc_r        <= cc_nxt;
      accepted_r  <= accepted_nxt;
      skip_r      <= skip_nxt;
      pointer_r   <= pointer_nxt;
      first_r     <= first_nxt;
    end
  end

  // output register, refilled whenever it is empty or drained this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r  <= in_stream_byte;
      out_pid_r   <= pid_r;
      out_cc_r    <= cc_r;
      out_start_r <= first_r;
      out_last_r  <= last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_payload_byte     = out_byte_r;
  assign out_stream_pid       = out_pid_r;
  assign out_continuity_count = out_cc_r;
  assign out_section_start    = out_start_r;
  assign out_packet_last      = out_last_r;

`ifndef NO_ASSERTIONS
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_packet_r |-> (pos_r <= tspf_pkg::LAST_POS))
    else $error("packet position beyond packet length");

  a_hunt_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !in_packet_r |-> (pos_r == '0))
    else $error("position not cleared while hunting");

  a_last_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && active && last) |=> !in_packet_r)
    else $error("final packet byte did not return to hunting");

  a_emit_shown: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("payload byte lost on its way to the output register");
`endif

endmodule
